// ===== hdl/ps2md_pkg.sv =====
`default_nettype none

package ps2md_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int MAX_BYTES   = 4;

	localparam logic [7:0] BYTE_ACK   = 8'hFA;
	localparam logic [7:0] BYTE_ERROR = 8'hFC;
	localparam logic [7:0] BYTE_BAT   = 8'hAA;
	localparam logic [7:0] BYTE_ID    = 8'h00;

	localparam logic [7:0] CMD_SCALE1      = 8'hE6;
	localparam logic [7:0] CMD_SCALE2      = 8'hE7;
	localparam logic [7:0] CMD_SET_RES     = 8'hE8;
	localparam logic [7:0] CMD_STATUS      = 8'hE9;
	localparam logic [7:0] CMD_STREAM      = 8'hEA;
	localparam logic [7:0] CMD_READ        = 8'hEB;
	localparam logic [7:0] CMD_WRAP_OFF    = 8'hEC;
	localparam logic [7:0] CMD_WRAP        = 8'hEE;
	localparam logic [7:0] CMD_REMOTE      = 8'hF0;
	localparam logic [7:0] CMD_GET_ID      = 8'hF2;
	localparam logic [7:0] CMD_SET_RATE    = 8'hF3;
	localparam logic [7:0] CMD_ENABLE      = 8'hF4;
	localparam logic [7:0] CMD_DISABLE     = 8'hF5;
	localparam logic [7:0] CMD_DEFAULTS    = 8'hF6;
	localparam logic [7:0] CMD_REPEAT_LAST = 8'hFE;
	localparam logic [7:0] CMD_RESET       = 8'hFF;

	localparam logic [1:0] DEV_RESET  = 2'd0;
	localparam logic [1:0] DEV_STREAM = 2'd1;
	localparam logic [1:0] DEV_REMOTE = 2'd2;
	localparam logic [1:0] DEV_WRAP   = 2'd3;

	localparam logic [7:0] DEFAULT_RATE = 8'd100;
	localparam logic [7:0] DEFAULT_RES  = 8'd2;

	typedef struct packed {
		logic              mode;
		logic [7:0]        host_byte;
		logic signed [15:0] move_dx;
		logic signed [15:0] move_dy;
		logic              button_left;
		logic              button_right;
		logic              button_middle;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic [1:0] device_mode;
		logic       reporting_on;
		logic [7:0] rate_setting;
		logic [7:0] resolution_setting;
	} result_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0]       data;
		logic [$clog2(MAX_BYTES)-1:0]    last_idx;
		logic [1:0]                      device_mode;
		logic                            reporting_on;
		logic [7:0]                      rate_setting;
		logic [7:0]                      resolution_setting;
	} resp_t;

endpackage

`default_nettype wire

// ===== hdl/ps2_mouse_device_responder_top.sv =====
// A response is registered in the queue, then in the back end, before its first byte is valid.
// Throughput: one response byte per cycle while result_ready is high; a transaction yields one
// to four bytes, which the byte serializer in the back end sends in order.
// Input transactions are taken every cycle while the two-entry response queue has room.
// Reset clears the queue and all mode state; rate returns to 100 and resolution to 2.
`default_nettype none

module ps2_mouse_device_responder_top
	import ps2md_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	logic  push, full, pop, not_empty;
	resp_t push_data, pop_data;

	ps2md_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.queue_full (full),
		.push       (push),
		.push_data  (push_data)
	);

	ps2md_fifo #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	ps2md_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_valid  (not_empty),
		.queue_data   (pop_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== hdl/ps2md_front.sv =====
`default_nettype none

module ps2md_front
	import ps2md_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	input  wire logic  queue_full,
	output logic       push,
	output resp_t      push_data
);

	typedef enum logic [1:0] {AW_NONE, AW_RES, AW_RATE} await_t;

	await_t     await_q, await_n;
	logic [1:0] mode_q, mode_n, saved_q, saved_n;
	logic       rep_q, rep_n;
	logic [7:0] rate_q, rate_n, res_q, res_n, last_q, last_n;
	logic [2:0] btn_q, btn_n;

	logic       ox, oy;
	logic [8:0] sx, sy;
	logic [7:0] pkt0;

	assign item_ready = !queue_full;
	assign push       = item_valid && item_ready;

	always_comb begin
		ox = (item.move_dx > 16'sd255) || (item.move_dx < -16'sd255);
		oy = (item.move_dy > 16'sd255) || (item.move_dy < -16'sd255);
		sx = ox ? (item.move_dx[15] ? 9'h101 : 9'h0FF) : item.move_dx[8:0];
		sy = oy ? (item.move_dy[15] ? 9'h101 : 9'h0FF) : item.move_dy[8:0];
		pkt0 = {oy, ox, sy[8], sx[8], 1'b1,
			item.button_middle, item.button_right, item.button_left};
	end

	always_comb begin
		await_n = await_q;
		mode_n  = mode_q;
		saved_n = saved_q;
		rep_n   = rep_q;
		rate_n  = rate_q;
		res_n   = res_q;
		last_n  = last_q;
		btn_n   = btn_q;
		push_data = '0;
		if (item.mode) begin
			btn_n = {item.button_middle, item.button_right, item.button_left};
			push_data.data[0] = pkt0;
			push_data.data[1] = sx[7:0];
			push_data.data[2] = sy[7:0];
			push_data.last_idx = 2'd2;
		end else if (await_q == AW_RES) begin
			res_n = item.host_byte;
			await_n = AW_NONE;
			push_data.data[0] = BYTE_ACK;
			last_n = BYTE_ACK;
		end else if (await_q == AW_RATE) begin
			rate_n = item.host_byte;
			await_n = AW_NONE;
			push_data.data[0] = BYTE_ACK;
			last_n = BYTE_ACK;
		end else begin
			await_n = AW_NONE;
			push_data.data[0] = BYTE_ACK;
			last_n = BYTE_ACK;
			unique case (item.host_byte) inside
				CMD_SCALE1, CMD_SCALE2, CMD_STATUS, CMD_RESET: begin
				end
				CMD_SET_RES: await_n = AW_RES;
				CMD_SET_RATE: await_n = AW_RATE;
				CMD_STREAM: begin
					saved_n = mode_q;
					mode_n = DEV_STREAM;
				end
				CMD_REMOTE: begin
					saved_n = mode_q;
					mode_n = DEV_REMOTE;
				end
				CMD_WRAP: begin
					saved_n = mode_q;
					mode_n = DEV_WRAP;
				end
				CMD_WRAP_OFF: mode_n = saved_q;
				CMD_READ: begin
					push_data.data[1] = {5'b00001, btn_q};
					push_data.data[2] = 8'h01;
					push_data.data[3] = 8'h01;
					push_data.last_idx = 2'd3;
				end
				CMD_GET_ID: begin
					push_data.data[1] = BYTE_ID;
					push_data.last_idx = 2'd1;
				end
				CMD_ENABLE: rep_n = 1'b1;
				CMD_DISABLE: rep_n = 1'b0;
				CMD_DEFAULTS: begin
					mode_n = DEV_RESET;
					rate_n = DEFAULT_RATE;
					res_n = DEFAULT_RES;
					rep_n = 1'b0;
					btn_n = 3'b000;
					last_n = BYTE_BAT;
					push_data.data[1] = BYTE_BAT;
					push_data.data[2] = BYTE_ID;
					push_data.last_idx = 2'd2;
				end
				CMD_REPEAT_LAST: begin
					push_data.data[0] = last_q;
					last_n = last_q;
				end
				default: begin
					push_data.data[0] = BYTE_ERROR;
					last_n = BYTE_ERROR;
				end
			endcase
		end
		push_data.device_mode = mode_n;
		push_data.reporting_on = rep_n;
		push_data.rate_setting = rate_n;
		push_data.resolution_setting = res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q <= AW_NONE;
			mode_q  <= DEV_RESET;
			saved_q <= DEV_RESET;
			rep_q   <= 1'b0;
			rate_q  <= DEFAULT_RATE;
			res_q   <= DEFAULT_RES;
			last_q  <= 8'h00;
			btn_q   <= 3'b000;
		end else if (push) begin
			await_q <= await_n;
			mode_q  <= mode_n;
			saved_q <= saved_n;
			rep_q   <= rep_n;
			rate_q  <= rate_n;
			res_q   <= res_n;
			last_q  <= last_n;
			btn_q   <= btn_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ps2md_fifo.sv =====
`default_nettype none

module ps2md_fifo
	import ps2md_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire resp_t push_data,
	output logic       full,
	input  wire logic  pop,
	output logic       not_empty,
	output resp_t      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	resp_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ps2md_back.sv =====
`default_nettype none

module ps2md_back
	import ps2md_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  queue_valid,
	input  wire resp_t queue_data,
	output logic       pop,
	output logic       result_valid,
	input  wire logic  result_ready,
	output result_t    result
);

	resp_t                        cur_q;
	logic [$clog2(MAX_BYTES)-1:0] idx_q;
	logic                         busy_q;
	logic                         is_last, fire;

	assign is_last      = (idx_q == cur_q.last_idx);
	assign fire         = busy_q && result_ready;
	assign pop          = queue_valid && (!busy_q || (fire && is_last));
	assign result_valid = busy_q;

	always_comb begin
		result.out_byte           = cur_q.data[idx_q];
		result.last_of_run        = is_last;
		result.device_mode        = cur_q.device_mode;
		result.reporting_on       = cur_q.reporting_on;
		result.rate_setting       = cur_q.rate_setting;
		result.resolution_setting = cur_q.resolution_setting;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= queue_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ps2md_checker.sv =====
`default_nettype none

module ps2md_checker
	import ps2md_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_ready,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	logic [1:0] run_q;
	logic       out_fire;

	assign out_fire = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 2'd0;
		end else if (out_fire) begin
			run_q <= result.last_of_run ? 2'd0 : run_q + 2'd1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("Input transaction changed while waiting.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("Result changed while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !result.last_of_run |=> result_valid &&
		result.device_mode == $past(result.device_mode) &&
		result.reporting_on == $past(result.reporting_on) &&
		result.rate_setting == $past(result.rate_setting) &&
		result.resolution_setting == $past(result.resolution_setting))
		else $error("Status fields changed within one response.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && run_q == 2'd3 |-> result.last_of_run)
		else $error("Response longer than four bytes.");

endmodule

bind ps2_mouse_device_responder_top ps2md_checker u_chk (.*);

`default_nettype wire
